// ----- rtl/asr_pkg.sv -----
// Shared types, codes and constants of the audio scope spectrum renderer.
package asr_pkg;

	localparam int FRAME_COL_W  = 8;
	localparam int FRAME_ROW_W  = 7;
	localparam int FRAME_ADDR_W = FRAME_ROW_W + FRAME_COL_W;
	localparam int FRAME_DEPTH  = 1 << FRAME_ADDR_W;
	localparam int PEAK_W       = 6;
	localparam int BAR_IDX_W    = 7;
	localparam int PEAK_DEPTH   = 1 << BAR_IDX_W;
	localparam int PEN_W        = 8;
	localparam int NUM_PEN_REGS = 8;
	localparam int CFG_INDEX_W  = 3;
	localparam int CFG_DATA_W   = 64;
	localparam int SAMPLE_W     = 16;
	localparam int LEVEL_W      = 8;
	localparam int BIN_W        = 8;

	localparam logic [PEN_W-1:0]       BACKGROUND_PEN = 8'd1;
	localparam logic [PEN_W-1:0]       TRACE_PEN      = 8'd2;
	localparam logic [PEAK_W-1:0]      PEAK_DECAY     = 6'd4;
	localparam logic [FRAME_ROW_W-1:0] FRAME_CENTRE   = 7'd64;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_WAVE  = 2'd1,
		OP_BIN   = 2'd2,
		OP_READ  = 2'd3
	} asr_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_WAVE,
		ST_READ,
		ST_READ_DATA,
		ST_PEAK_RD,
		ST_PEAK_UPD,
		ST_DRAW_TOP,
		ST_DRAW_BOT
	} asr_state_t;

	typedef struct packed {
		logic capture;
		logic clr_step;
		logic wave_wr;
		logic frame_rd;
		logic peak_rd;
		logic peak_upd;
		logic draw_top;
		logic draw_bot;
		logic load_pixel;
	} asr_cmd_t;

	typedef struct packed {
		asr_op_t in_op;
		logic    in_bin_ok;
		logic    clear_last;
		logic    peak_zero;
		logic    draw_last;
	} asr_sts_t;

endpackage

// ----- rtl/asr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module asr_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/asr_dp.sv -----
// Datapath: item registers, colour table, frame and peak stores, draw counters.
module asr_dp import asr_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  asr_cmd_t                cmd,
	output asr_sts_t                sts,
	input  logic [1:0]              op,
	input  logic                    channel,
	input  logic [FRAME_COL_W-1:0]  column,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic [BIN_W-1:0]        bin_index,
	input  logic [LEVEL_W-1:0]      level,
	input  logic [FRAME_ADDR_W-1:0] address,
	input  logic                    cfg_we,
	input  logic [CFG_INDEX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	output logic [PEN_W-1:0]        pixel
);

	logic [CFG_DATA_W-1:0]   pens_q [NUM_PEN_REGS];
	logic [FRAME_ADDR_W-1:0] wave_addr_q;
	logic [FRAME_ADDR_W-1:0] rd_addr_q;
	logic [BAR_IDX_W-1:0]    bar_idx_q;
	logic [PEAK_W-1:0]       lvl_q;
	logic [FRAME_ADDR_W-1:0] clr_q;
	logic [PEAK_W-1:0]       m_q;
	logic [PEAK_W-1:0]       k_q;
	logic [PEAK_DEPTH-1:0]   peak_vld_q;
	logic [PEN_W-1:0]        pixel_q;

	logic [PEAK_W-1:0]       bar;
	logic [PEAK_W-1:0]       peak_rdata;
	logic [PEAK_W-1:0]       peak_cur;
	logic [PEAK_W-1:0]       peak_new;
	logic [PEN_W-1:0]        pen_sel;
	logic [FRAME_ROW_W-1:0]  row_top;
	logic [FRAME_ROW_W-1:0]  row_bot;
	logic [FRAME_COL_W-1:0]  bar_col;
	logic                    fr_we;
	logic [FRAME_ADDR_W-1:0] fr_waddr;
	logic [PEN_W-1:0]        fr_wdata;
	logic [PEN_W-1:0]        fr_rdata;

	// Channel 0 bars run right to left, channel 1 left to right.
	assign bar = channel ? bin_index[BIN_W-1:2] : ~bin_index[BIN_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PEN_REGS; i++) begin
				pens_q[i] <= '0;
			end
		end else if (cfg_we) begin
			pens_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			// (sample >>> 10) + 32 flips the sign bit of the top six bits
			wave_addr_q <= {channel, ~sample[SAMPLE_W-1], sample[SAMPLE_W-2:10], column};
			rd_addr_q   <= address;
			bar_idx_q   <= {channel, bar};
			lvl_q       <= level[LEVEL_W-1:2];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + 1'b1;
		end
		if (cmd.peak_upd) begin
			m_q <= peak_new;
			k_q <= '0;
		end else if (cmd.draw_bot) begin
			k_q <= k_q + 1'b1;
		end
		if (cmd.load_pixel) begin
			pixel_q <= fr_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_vld_q <= '0;
		end else if (cmd.peak_upd) begin
			peak_vld_q[bar_idx_q] <= 1'b1;
		end
	end

	// Peak: rise at once, else decay and stop at zero.
	always_comb begin
		peak_cur = peak_vld_q[bar_idx_q] ? peak_rdata : '0;
		if (lvl_q >= peak_cur) begin
			peak_new = lvl_q;
		end else if (peak_cur > PEAK_DECAY) begin
			peak_new = peak_cur - PEAK_DECAY;
		end else begin
			peak_new = '0;
		end
	end

	assign pen_sel = pens_q[k_q[PEAK_W-1:3]][{k_q[2:0], 3'b000} +: PEN_W];
	assign row_top = FRAME_CENTRE - {1'b0, m_q} + {1'b0, k_q};
	assign row_bot = FRAME_CENTRE - 1'b1 + {1'b0, m_q} - {1'b0, k_q};
	assign bar_col = {bar_idx_q, 1'b0};

	always_comb begin
		fr_we    = cmd.clr_step | cmd.wave_wr | cmd.draw_top | cmd.draw_bot;
		fr_waddr = clr_q;
		fr_wdata = BACKGROUND_PEN;
		if (cmd.wave_wr) begin
			fr_waddr = wave_addr_q;
			fr_wdata = TRACE_PEN;
		end else if (cmd.draw_top) begin
			fr_waddr = {row_top, bar_col};
			fr_wdata = pen_sel;
		end else if (cmd.draw_bot) begin
			fr_waddr = {row_bot, bar_col};
			fr_wdata = pen_sel;
		end
	end

	asr_ram #(.DATA_W(PEN_W), .DEPTH(FRAME_DEPTH)) u_frame (
		.clk   (clk),
		.we    (fr_we),
		.waddr (fr_waddr),
		.wdata (fr_wdata),
		.re    (cmd.frame_rd),
		.raddr (rd_addr_q),
		.rdata (fr_rdata)
	);

	asr_ram #(.DATA_W(PEAK_W), .DEPTH(PEAK_DEPTH)) u_peak (
		.clk   (clk),
		.we    (cmd.peak_upd),
		.waddr (bar_idx_q),
		.wdata (peak_new),
		.re    (cmd.peak_rd),
		.raddr (bar_idx_q),
		.rdata (peak_rdata)
	);

	assign sts.in_op      = asr_op_t'(op);
	assign sts.in_bin_ok  = (bin_index[1:0] == 2'b00);
	assign sts.clear_last = &clr_q;
	assign sts.peak_zero  = (peak_new == '0);
	assign sts.draw_last  = ((k_q + 1'b1) == m_q);
	assign pixel          = pixel_q;

endmodule

// ----- rtl/asr_ctrl.sv -----
// Controller: sequences clear, plot, bar draw and read through the datapath.
module asr_ctrl import asr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  asr_sts_t sts,
	output asr_cmd_t cmd
);

	asr_state_t state_q;
	asr_state_t state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (sts.in_op)
						OP_CLEAR: state_d = ST_CLEAR;
						OP_WAVE:  state_d = ST_WAVE;
						OP_BIN:   state_d = sts.in_bin_ok ? ST_PEAK_RD : ST_IDLE;
						OP_READ:  state_d = ST_READ;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_CLEAR:     if (sts.clear_last) state_d = ST_IDLE;
			ST_WAVE:      state_d = ST_IDLE;
			ST_READ:      state_d = ST_READ_DATA;
			ST_READ_DATA: if (out_free) state_d = ST_IDLE;
			ST_PEAK_RD:   state_d = ST_PEAK_UPD;
			ST_PEAK_UPD:  state_d = sts.peak_zero ? ST_IDLE : ST_DRAW_TOP;
			ST_DRAW_TOP:  state_d = ST_DRAW_BOT;
			ST_DRAW_BOT:  state_d = sts.draw_last ? ST_IDLE : ST_DRAW_TOP;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_CLEAR:     cmd.clr_step   = 1'b1;
			ST_WAVE:      cmd.wave_wr    = 1'b1;
			ST_READ:      cmd.frame_rd   = 1'b1;
			ST_READ_DATA: cmd.load_pixel = out_free;
			ST_PEAK_RD:   cmd.peak_rd    = 1'b1;
			ST_PEAK_UPD:  cmd.peak_upd   = 1'b1;
			ST_DRAW_TOP:  cmd.draw_top   = 1'b1;
			ST_DRAW_BOT:  cmd.draw_bot   = 1'b1;
			default:      cmd            = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_pixel) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- rtl/audio_scope_spectrum_renderer_top.sv -----
// Top level of the audio scope spectrum renderer: 256x128 pen-index frame store.
// Per item: a waveform point plots one pixel, a read loads one pixel for output, a
// bin updates its peak and draws its bar, a clear sweeps the frame; off-grid bins skip.
// The single write port of the frame store writes one pixel per cycle.
// Asynchronous active-low reset clears the controller, colour table and peak valid
// bits; the frame store holds no defined contents until the first clear.
module audio_scope_spectrum_renderer_top import asr_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 op,
	input  logic                       channel,
	input  logic [FRAME_COL_W-1:0]     column,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic [BIN_W-1:0]           bin_index,
	input  logic [LEVEL_W-1:0]         level,
	input  logic [FRAME_ADDR_W-1:0]    address,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [PEN_W-1:0]           pixel,
	input  logic                       cfg_we,
	input  logic [CFG_INDEX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data
);

	asr_cmd_t cmd;
	asr_sts_t sts;

	// Controller: owns the sequencing state and the result-valid flag. It takes a
	// new transfer only from idle, but a finished pixel may still wait in the output
	// register while the next item is already at work.
	asr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: latches the item, holds the colour table, both stores, the clear
	// sweep counter and the bar row counter; the pixel register sits here too.
	asr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.op        (op),
		.channel   (channel),
		.column    (column),
		.sample    (sample),
		.bin_index (bin_index),
		.level     (level),
		.address   (address),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixel     (pixel)
	);

	// A transfer takes the block out of idle, except a bin off the grid of four, which
	// is dropped on the spot.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !(sts.in_op == OP_BIN && !sts.in_bin_ok)) |=> !in_ready)
		else $error("input taken again right after a transfer");

	// The peak update must use data read on the previous cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.peak_upd |-> $past(cmd.peak_rd))
		else $error("peak update without a preceding peak read");

	// Each mirrored lower pixel follows its upper pixel.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.draw_bot |-> $past(cmd.draw_top))
		else $error("lower bar pixel without upper bar pixel");

	// Never load a pixel over one that is still waiting and not being taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_pixel |-> (!out_valid || out_ready))
		else $error("pixel register overwritten while held");

endmodule
